// ----- rtl/aona_pkg.sv -----
// Package for the all-or-nothing resource allocator: widths, codes and request type.
// No dependencies; used by every module under rtl/.
`default_nettype none
package aona_pkg;

  localparam int MAX_TYPES      = 8;
  localparam int NUM_TYPES_DEF  = 8;
  localparam int TASK_COUNT_DEF = 32;
  localparam int TASK_W         = 5;
  localparam int UNIT_W         = 8;
  localparam int STATUS_W       = 2;
  localparam int TYPE_W         = 3;
  localparam int CFG_IDX_W      = 4;
  localparam int QUEUE_DEPTH    = 2;

  // result status codes
  localparam logic [STATUS_W-1:0] STS_GRANTED  = 2'd0;
  localparam logic [STATUS_W-1:0] STS_SHORT    = 2'd1;
  localparam logic [STATUS_W-1:0] STS_RELEASED = 2'd2;
  localparam logic [STATUS_W-1:0] STS_HOLDING  = 2'd3;

  // input command codes
  localparam logic CMD_ACQUIRE = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  // classified operation codes
  localparam logic [1:0] OP_ACQ     = 2'd0;
  localparam logic [1:0] OP_REL     = 2'd1;
  localparam logic [1:0] OP_BAD_ACQ = 2'd2;
  localparam logic [1:0] OP_BAD_REL = 2'd3;

  typedef logic [UNIT_W-1:0] unit_t;

  typedef struct packed {
    logic [1:0]                  op;
    logic [TASK_W-1:0]           task_id;
    unit_t [MAX_TYPES-1:0]       need;
  } req_t;

endpackage
`default_nettype wire

// ----- rtl/aona_front.sv -----
// Front end: accepts request beats and classifies them by command and task range.
// Depends on aona_pkg; feeds aona_fifo.
`default_nettype none
module aona_front #(
  parameter int TASK_COUNT = aona_pkg::TASK_COUNT_DEF
) (
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire logic                                  in_cmd,
  input  wire logic [aona_pkg::TASK_W-1:0]           in_task_id,
  input  wire aona_pkg::unit_t [aona_pkg::MAX_TYPES-1:0] in_need,
  input  wire logic                                  q_full,
  output logic                                       q_push,
  output aona_pkg::req_t                             q_data
);
  import aona_pkg::*;

  logic in_range;

  assign in_range = int'(in_task_id) < TASK_COUNT;
  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_data         = '0;
    q_data.task_id = in_task_id;
    q_data.need    = in_need;
    if (in_cmd == CMD_RELEASE) begin
      q_data.op = in_range ? OP_REL : OP_BAD_REL;
    end else begin
      q_data.op = in_range ? OP_ACQ : OP_BAD_ACQ;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/aona_fifo.sv -----
// Short request queue between front and back ends.
// Depends on aona_pkg for the request type.
`default_nettype none
module aona_fifo #(
  parameter int DEPTH = aona_pkg::QUEUE_DEPTH
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire aona_pkg::req_t push_data,
  output logic                full,
  input  wire logic           pop,
  output logic                not_empty,
  output aona_pkg::req_t      pop_data
);
  import aona_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  req_t             slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full      = cnt_r == CNT_W'(DEPTH);
  assign not_empty = cnt_r != '0;
  assign pop_data  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/aona_back.sv -----
// Back end: pool usage, per-task holdings memory, grant/release execution, result register.
// Depends on aona_pkg; takes requests from aona_fifo.
`default_nettype none
module aona_back #(
  parameter int NUM_TYPES  = aona_pkg::NUM_TYPES_DEF,
  parameter int TASK_COUNT = aona_pkg::TASK_COUNT_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire aona_pkg::unit_t [aona_pkg::MAX_TYPES-1:0] cap,
  input  wire logic                                  q_valid,
  input  wire aona_pkg::req_t                        q_data,
  output logic                                       q_pop,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic [aona_pkg::STATUS_W-1:0]              out_status,
  output logic [aona_pkg::TASK_W-1:0]                out_task_echo,
  output logic [aona_pkg::TYPE_W-1:0]                out_short_type
);
  import aona_pkg::*;

  localparam int TIDX_W = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;
  localparam int ROW_W  = NUM_TYPES * UNIT_W;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic                  state_r, state_nxt;
  req_t                  cur_r;
  logic [ROW_W-1:0]      held_rd_r;
  logic [ROW_W-1:0]      held_mem [TASK_COUNT];
  unit_t [NUM_TYPES-1:0] use_r, use_nxt;
  logic [TASK_COUNT-1:0] holding_r, holding_nxt;
  logic                  out_valid_r;
  logic [STATUS_W-1:0]   out_status_r;
  logic [TASK_W-1:0]     out_task_r;
  logic [TYPE_W-1:0]     out_short_r;

  logic [TIDX_W-1:0]    q_idx, cur_idx;
  logic                 exec_go;
  logic [NUM_TYPES-1:0] short_hit;
  logic [TYPE_W-1:0]    first_short;
  logic [ROW_W-1:0]     grant_row;
  logic                 do_grant, do_release;
  logic [STATUS_W-1:0]  res_status;
  logic [TYPE_W-1:0]    res_short;
  unit_t                free_u, held_u;

  assign q_idx   = TIDX_W'(q_data.task_id);
  assign cur_idx = TIDX_W'(cur_r.task_id);
  assign q_pop   = (state_r == ST_IDLE) && q_valid;
  assign exec_go = (state_r == ST_EXEC) && (!out_valid_r || out_ready);

  always_comb begin
    short_hit   = '0;
    first_short = '0;
    grant_row   = '0;
    for (int t = NUM_TYPES - 1; t >= 0; t--) begin
      free_u       = (cap[t] > use_r[t]) ? cap[t] - use_r[t] : '0;
      short_hit[t] = cur_r.need[t] > free_u;
      grant_row[t*UNIT_W +: UNIT_W] = cur_r.need[t];
      if (short_hit[t]) begin
        first_short = TYPE_W'(t);
      end
    end
  end

  always_comb begin
    do_grant   = 1'b0;
    do_release = 1'b0;
    res_short  = '0;
    case (cur_r.op)
      OP_ACQ: begin
        if (holding_r[cur_idx]) begin
          res_status = STS_HOLDING;
        end else if (|short_hit) begin
          res_status = STS_SHORT;
          res_short  = first_short;
        end else begin
          res_status = STS_GRANTED;
          do_grant   = 1'b1;
        end
      end
      OP_REL: begin
        res_status = STS_RELEASED;
        do_release = holding_r[cur_idx];
      end
      OP_BAD_ACQ: begin
        res_status = STS_SHORT;
      end
      default: begin
        res_status = STS_RELEASED;
      end
    endcase
  end

  always_comb begin
    state_nxt   = state_r;
    use_nxt     = use_r;
    holding_nxt = holding_r;
    held_u      = '0;
    if (q_pop) begin
      state_nxt = ST_EXEC;
    end
    if (exec_go) begin
      state_nxt = ST_IDLE;
      for (int t = 0; t < NUM_TYPES; t++) begin
        held_u = held_rd_r[t*UNIT_W +: UNIT_W];
        if (do_grant) begin
          use_nxt[t] = use_r[t] + cur_r.need[t];
        end else if (do_release) begin
          use_nxt[t] = (use_r[t] > held_u) ? use_r[t] - held_u : '0;
        end
      end
      if (do_grant) begin
        holding_nxt[cur_idx] = 1'b1;
      end else if (do_release) begin
        holding_nxt[cur_idx] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      use_r       <= '0;
      holding_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      use_r     <= use_nxt;
      holding_r <= holding_nxt;
      if (exec_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_data;
    end
    if (exec_go) begin
      out_status_r <= res_status;
      out_task_r   <= cur_r.task_id;
      out_short_r  <= res_short;
    end
  end

  // holdings memory: rows valid only while the task's holding bit is set
  always_ff @(posedge clk) begin
    if (exec_go && do_grant) begin
      held_mem[cur_idx] <= grant_row;
    end
    if (q_pop) begin
      held_rd_r <= held_mem[q_idx];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_task_echo  = out_task_r;
  assign out_short_type = out_short_r;

  a_grant_sets_holding: assert property (@(posedge clk) disable iff (!rst_n)
    (exec_go && do_grant) |=> holding_r[cur_idx])
    else $error("grant did not mark task as holding");

  a_release_clears_holding: assert property (@(posedge clk) disable iff (!rst_n)
    (exec_go && do_release) |=> !holding_r[cur_idx])
    else $error("release did not clear task holding");

  a_exec_waits_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EXEC && out_valid_r && !out_ready) |=> (state_r == ST_EXEC))
    else $error("request executed while result beat was stalled");

endmodule
`default_nettype wire

// ----- rtl/all_or_nothing_resource_allocator_core.sv -----
// Requests go from the queue into the request/holdings-row registers, then a result register.
// The back end takes one request at a time: holdings row read, then execute.
// A 2-entry queue lets requests be accepted while a result beat waits.
// Reset (rst_n low, synchronous): capacities, pool usage and task holdings cleared; no sweep.
// Holds the capacity registers and ties aona_front, aona_fifo and aona_back together.
`default_nettype none
module all_or_nothing_resource_allocator_core #(
  parameter int NUM_TYPES  = aona_pkg::NUM_TYPES_DEF,
  parameter int TASK_COUNT = aona_pkg::TASK_COUNT_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [aona_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [aona_pkg::UNIT_W-1:0]      cfg_data,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic                             in_cmd,
  input  wire logic [aona_pkg::TASK_W-1:0]      in_task_id,
  input  wire logic [aona_pkg::UNIT_W-1:0]      in_need_type0,
  input  wire logic [aona_pkg::UNIT_W-1:0]      in_need_type1,
  input  wire logic [aona_pkg::UNIT_W-1:0]      in_need_type2,
  input  wire logic [aona_pkg::UNIT_W-1:0]      in_need_type3,
  input  wire logic [aona_pkg::UNIT_W-1:0]      in_need_type4,
  input  wire logic [aona_pkg::UNIT_W-1:0]      in_need_type5,
  input  wire logic [aona_pkg::UNIT_W-1:0]      in_need_type6,
  input  wire logic [aona_pkg::UNIT_W-1:0]      in_need_type7,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [aona_pkg::STATUS_W-1:0]         out_status,
  output logic [aona_pkg::TASK_W-1:0]           out_task_echo,
  output logic [aona_pkg::TYPE_W-1:0]          out_short_type
);
  import aona_pkg::*;

  unit_t [MAX_TYPES-1:0] cap_r;
  unit_t [MAX_TYPES-1:0] need;
  logic                  q_push, q_full, q_pop, q_not_empty;
  req_t                  push_data, pop_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= '0;
    end else if (cfg_valid && (cfg_index < CFG_IDX_W'(MAX_TYPES))) begin
      cap_r[cfg_index[TYPE_W-1:0]] <= cfg_data;
    end
  end

  assign need[0] = in_need_type0;
  assign need[1] = in_need_type1;
  assign need[2] = in_need_type2;
  assign need[3] = in_need_type3;
  assign need[4] = in_need_type4;
  assign need[5] = in_need_type5;
  assign need[6] = in_need_type6;
  assign need[7] = in_need_type7;

  aona_front #(
    .TASK_COUNT (TASK_COUNT)
  ) u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_cmd     (in_cmd),
    .in_task_id (in_task_id),
    .in_need    (need),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_data     (push_data)
  );

  aona_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_data  (pop_data)
  );

  aona_back #(
    .NUM_TYPES  (NUM_TYPES),
    .TASK_COUNT (TASK_COUNT)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cap            (cap_r),
    .q_valid        (q_not_empty),
    .q_data         (pop_data),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_task_echo  (out_task_echo),
    .out_short_type (out_short_type)
  );

endmodule
`default_nettype wire
